// ===== sv/rpc_pkg.sv =====
// Shared types, constants and helper functions for the rigid pose composer.
`timescale 1ns / 1ps
package rpc_pkg;

  localparam int QW     = 16;   // quaternion component width, Q1.14
  localparam int PW     = 32;   // position component width, Q15.16
  localparam int DATA_W = 4 * QW + 3 * PW;
  localparam int UOUT_W = 2;

  localparam int PR_W   = 2 * QW + 2;   // raw quaternion product component
  localparam int U_W    = 27;           // normalized quaternion, signed
  localparam int T_W    = 36;           // cross product term, signed
  localparam int MA_W   = U_W;          // multiplier operand a
  localparam int MB_W   = T_W;          // multiplier operand b
  localparam int ACC_W  = 64;
  localparam int RR_W   = 40;           // rotated offset before the final add
  localparam int SUM_W  = 42;
  localparam int SQ_W   = 34;           // sum of four 16-bit squares
  localparam int ROOT_W = 62;
  localparam int DQ_W   = 26;           // longest quotient
  localparam int NUM_W  = 56;
  localparam int R_W    = 32;

  localparam int DQ_FINE   = 26;        // quotient bits for the Q.24 result
  localparam int DQ_COARSE = 16;        // quotient bits for the Q.14 result
  localparam int SH_FINE   = 38;
  localparam int SH_COARSE = 28;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_COMPOSE = 1'b1;

  localparam logic signed [QW-1:0] QUAT_ONE = QW'(1 << (QW - 2));

  typedef struct packed {
    logic start;
    logic fine;     // 1: Q.24 result, 0: Q.14 result
  } norm_req_t;

  typedef struct packed {
    logic done;
    logic nonzero;
  } norm_rsp_t;

  typedef struct packed {
    logic en;
    logic first;
    logic sub;
  } mac_ctl_t;

  typedef struct packed {
    logic [1:0] ai;
    logic [1:0] bi;
    logic       sub;
  } term_sel_t;

  // Hamilton product, parent on the left: a = parent, b = child.
  function automatic term_sel_t prod_term(input logic [1:0] comp, input logic [1:0] term);
    term_sel_t r;
    case ({comp, term})
      4'h0: r = '{2'd3, 2'd0, 1'b0};
      4'h1: r = '{2'd0, 2'd3, 1'b0};
      4'h2: r = '{2'd1, 2'd2, 1'b0};
      4'h3: r = '{2'd2, 2'd1, 1'b1};
      4'h4: r = '{2'd3, 2'd1, 1'b0};
      4'h5: r = '{2'd0, 2'd2, 1'b1};
      4'h6: r = '{2'd1, 2'd3, 1'b0};
      4'h7: r = '{2'd2, 2'd0, 1'b0};
      4'h8: r = '{2'd3, 2'd2, 1'b0};
      4'h9: r = '{2'd0, 2'd1, 1'b0};
      4'ha: r = '{2'd1, 2'd0, 1'b1};
      4'hb: r = '{2'd2, 2'd3, 1'b0};
      4'hc: r = '{2'd3, 2'd3, 1'b0};
      4'hd: r = '{2'd0, 2'd0, 1'b1};
      4'he: r = '{2'd1, 2'd1, 1'b1};
      default: r = '{2'd2, 2'd2, 1'b1};
    endcase
    return r;
  endfunction

  // u_vec x v: a = u, b = child position.
  function automatic term_sel_t cross_term(input logic [1:0] comp, input logic [1:0] term);
    term_sel_t r;
    case ({comp, term})
      4'h0: r = '{2'd1, 2'd2, 1'b0};
      4'h1: r = '{2'd2, 2'd1, 1'b1};
      4'h4: r = '{2'd2, 2'd0, 1'b0};
      4'h5: r = '{2'd0, 2'd2, 1'b1};
      4'h8: r = '{2'd0, 2'd1, 1'b0};
      4'h9: r = '{2'd1, 2'd0, 1'b1};
      default: r = '{2'd0, 2'd0, 1'b0};
    endcase
    return r;
  endfunction

  // u_w * t + u_vec x t: a = u, b = t.
  function automatic term_sel_t rot_term(input logic [1:0] comp, input logic [1:0] term);
    term_sel_t r;
    case ({comp, term})
      4'h0: r = '{2'd3, 2'd0, 1'b0};
      4'h1: r = '{2'd1, 2'd2, 1'b0};
      4'h2: r = '{2'd2, 2'd1, 1'b1};
      4'h4: r = '{2'd3, 2'd1, 1'b0};
      4'h5: r = '{2'd2, 2'd0, 1'b0};
      4'h6: r = '{2'd0, 2'd2, 1'b1};
      4'h8: r = '{2'd3, 2'd2, 1'b0};
      4'h9: r = '{2'd0, 2'd1, 1'b0};
      4'ha: r = '{2'd1, 2'd0, 1'b1};
      default: r = '{2'd0, 2'd0, 1'b0};
    endcase
    return r;
  endfunction

  // Round half away from zero while shifting right by s.
  function automatic logic signed [ACC_W-1:0] rnd_shift(input logic signed [ACC_W-1:0] x,
                                                        input int unsigned s);
    logic [ACC_W-1:0] m;
    m = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
    m = (m + (ACC_W'(1) << (s - 1))) >> s;
    return x[ACC_W-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [PW-1:0] sat_pos(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = (SUM_W'(1) <<< (PW - 1)) - SUM_W'(1);
    lo = -hi - SUM_W'(1);
    if (x > hi) return PW'(hi);
    if (x < lo) return PW'(lo);
    return PW'(x);
  endfunction

  function automatic logic signed [QW-1:0] sat_quat(input logic signed [U_W-1:0] x);
    logic signed [U_W-1:0] hi;
    logic signed [U_W-1:0] lo;
    hi = (U_W'(1) <<< (QW - 1)) - U_W'(1);
    lo = -hi - U_W'(1);
    if (x > hi) return QW'(hi);
    if (x < lo) return QW'(lo);
    return QW'(x);
  endfunction

endpackage

// ===== sv/rigid_pose_compose.sv =====
// Top level of the rigid pose composer: sequencer, operand select and result register.
// A load transaction is stored in the cycle it is accepted; a compose raises m_tvalid once
//   the product has been normalized (a zero parent skips the cross and rotate steps).
// No new input is accepted while a compose runs; its length is set by the serial square root
//   and the one-bit-per-cycle divider in the normalize unit, which runs twice per compose.
// Reset (rst, synchronous, active high): parent pose returns to zero position and the
//   identity quaternion, the sequencer goes idle and no result is pending.
`timescale 1ns / 1ps
module rigid_pose_compose (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // quat_x, quat_y, quat_z, quat_w, pos_x, pos_y, pos_z (lowest first)
  input  logic [rpc_pkg::DATA_W-1:0]   s_tdata,
  // kind
  input  logic [0:0]                   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // out_pos_x, out_pos_y, out_pos_z, out_quat_x, out_quat_y, out_quat_z, out_quat_w
  output logic [rpc_pkg::DATA_W-1:0]   m_tdata,
  // position_valid, orientation_valid
  output logic [rpc_pkg::UOUT_W-1:0]   m_tuser
);

  localparam int QW = rpc_pkg::QW;
  localparam int PW = rpc_pkg::PW;

  typedef enum logic [3:0] {
    S_IDLE, S_PROD, S_NP_GO, S_NP_WAIT, S_CROSS, S_ROT, S_FIN, S_NQ_GO, S_NQ_WAIT, S_OUT
  } state_t;

  state_t state;
  logic [1:0] comp;
  logic [2:0] term;

  // parent pose (model state) and the child being composed
  logic signed [QW-1:0] pa [4];
  logic signed [PW-1:0] pp [3];
  logic signed [QW-1:0] cb [4];
  logic signed [PW-1:0] cv [3];

  // intermediate results
  logic signed [rpc_pkg::PR_W-1:0] pr [4];
  logic signed [rpc_pkg::U_W-1:0]  u  [4];
  logic signed [rpc_pkg::T_W-1:0]  t  [3];
  logic signed [rpc_pkg::RR_W-1:0] rr [3];
  logic signed [PW-1:0]            op [3];
  logic signed [QW-1:0]            oq [4];
  logic                            pv;
  logic                            ov;

  rpc_pkg::mac_ctl_t  mac_ctl;
  rpc_pkg::term_sel_t sel;
  logic signed [rpc_pkg::MA_W-1:0]  mac_a;
  logic signed [rpc_pkg::MB_W-1:0]  mac_b;
  logic signed [rpc_pkg::ACC_W-1:0] acc;

  rpc_pkg::norm_req_t             nreq;
  rpc_pkg::norm_rsp_t             nrsp;
  logic [3:0][rpc_pkg::PR_W-1:0]  nin;
  logic [3:0][rpc_pkg::U_W-1:0]   nout;

  logic in_acc;
  logic out_load;

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  // Pick the term of the current component for the shared multiplier.
  always_comb begin
    sel     = rpc_pkg::prod_term(comp, term[1:0]);
    mac_a   = '0;
    mac_b   = '0;
    mac_ctl = '{en: 1'b0, first: (term == 3'd0), sub: 1'b0};
    case (state)
      S_PROD: begin
        sel         = rpc_pkg::prod_term(comp, term[1:0]);
        mac_a       = rpc_pkg::MA_W'(pa[sel.ai]);
        mac_b       = rpc_pkg::MB_W'(cb[sel.bi]);
        mac_ctl.en  = (term != 3'd4);
      end
      S_CROSS: begin
        sel         = rpc_pkg::cross_term(comp, term[1:0]);
        mac_a       = u[sel.ai];
        mac_b       = rpc_pkg::MB_W'(cv[sel.bi]);
        mac_ctl.en  = (term != 3'd2);
      end
      S_ROT: begin
        sel         = rpc_pkg::rot_term(comp, term[1:0]);
        mac_a       = u[sel.ai];
        mac_b       = t[sel.bi];
        mac_ctl.en  = (term != 3'd3);
      end
      default: begin
        mac_ctl.en = 1'b0;
      end
    endcase
    mac_ctl.sub = sel.sub;
  end

  // Normalize the parent first (Q.24 for the rotation), then the product (Q.14).
  always_comb begin
    nreq.start = (state == S_NP_GO) || (state == S_NQ_GO);
    nreq.fine  = (state == S_NP_GO);
    for (int i = 0; i < 4; i++) begin
      nin[i] = (state == S_NP_GO) ? rpc_pkg::PR_W'(pa[i]) : pr[i];
    end
  end

  rpc_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  rpc_norm u_norm (
    .clk (clk),
    .rst (rst),
    .req (nreq),
    .c   (nin),
    .rsp (nrsp),
    .o   (nout)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      comp     <= 2'd0;
      term     <= 3'd0;
      for (int i = 0; i < 3; i++) begin
        pa[i] <= '0;
        pp[i] <= '0;
      end
      pa[3] <= rpc_pkg::QUAT_ONE;
    end else begin
      // raise the result when the register is free, drop it once taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (s_tuser[0] == rpc_pkg::KIND_LOAD) begin
              for (int i = 0; i < 4; i++) begin
                pa[i] <= s_tdata[i*QW +: QW];
              end
              for (int i = 0; i < 3; i++) begin
                pp[i] <= s_tdata[4*QW + i*PW +: PW];
              end
            end else begin
              for (int i = 0; i < 4; i++) begin
                cb[i] <= s_tdata[i*QW +: QW];
              end
              for (int i = 0; i < 3; i++) begin
                cv[i] <= s_tdata[4*QW + i*PW +: PW];
              end
              comp  <= 2'd0;
              term  <= 3'd0;
              state <= S_PROD;
            end
          end
        end
        S_PROD: begin
          if (term == 3'd4) begin
            pr[comp] <= acc[rpc_pkg::PR_W-1:0];
            term     <= 3'd0;
            comp     <= comp + 2'd1;
            if (comp == 2'd3) begin
              state <= S_NP_GO;
            end
          end else begin
            term <= term + 3'd1;
          end
        end
        S_NP_GO: begin
          state <= S_NP_WAIT;
        end
        S_NP_WAIT: begin
          if (nrsp.done) begin
            pv <= nrsp.nonzero;
            for (int i = 0; i < 4; i++) begin
              u[i] <= nout[i];
            end
            comp <= 2'd0;
            term <= 3'd0;
            if (nrsp.nonzero) begin
              state <= S_CROSS;
            end else begin
              for (int i = 0; i < 3; i++) begin
                op[i] <= '0;
              end
              state <= S_NQ_GO;
            end
          end
        end
        S_CROSS: begin
          // t = 2 * (u_vec x v), rounded back to Q.16
          if (term == 3'd2) begin
            t[comp] <= rpc_pkg::T_W'(rpc_pkg::rnd_shift(acc, 23));
            term    <= 3'd0;
            if (comp == 2'd2) begin
              comp  <= 2'd0;
              state <= S_ROT;
            end else begin
              comp <= comp + 2'd1;
            end
          end else begin
            term <= term + 3'd1;
          end
        end
        S_ROT: begin
          if (term == 3'd3) begin
            rr[comp] <= rpc_pkg::RR_W'(rpc_pkg::rnd_shift(acc, 24));
            term     <= 3'd0;
            if (comp == 2'd2) begin
              comp  <= 2'd0;
              state <= S_FIN;
            end else begin
              comp <= comp + 2'd1;
            end
          end else begin
            term <= term + 3'd1;
          end
        end
        S_FIN: begin
          for (int i = 0; i < 3; i++) begin
            op[i] <= rpc_pkg::sat_pos(rpc_pkg::SUM_W'(pp[i]) + rpc_pkg::SUM_W'(cv[i])
                                      + rpc_pkg::SUM_W'(rr[i]));
          end
          state <= S_NQ_GO;
        end
        S_NQ_GO: begin
          state <= S_NQ_WAIT;
        end
        S_NQ_WAIT: begin
          if (nrsp.done) begin
            ov <= nrsp.nonzero;
            // a zero product falls back to the identity quaternion
            for (int i = 0; i < 3; i++) begin
              oq[i] <= nrsp.nonzero ? rpc_pkg::sat_quat(nout[i]) : '0;
            end
            oq[3] <= nrsp.nonzero ? rpc_pkg::sat_quat(nout[3]) : rpc_pkg::QUAT_ONE;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // hold here until the result register is free
          if (out_load) begin
            m_tdata  <= {oq[3], oq[2], oq[1], oq[0], op[2], op[1], op[0]};
            m_tuser  <= {ov, pv};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/rpc_mac.sv =====
// Shared signed multiply-accumulate unit.
`timescale 1ns / 1ps
module rpc_mac (
  input  logic                               clk,
  input  rpc_pkg::mac_ctl_t                  ctl,
  input  logic signed [rpc_pkg::MA_W-1:0]    a,
  input  logic signed [rpc_pkg::MB_W-1:0]    b,
  output logic signed [rpc_pkg::ACC_W-1:0]   acc
);

  logic signed [rpc_pkg::MA_W+rpc_pkg::MB_W-1:0] prod;
  logic signed [rpc_pkg::ACC_W-1:0]              ext;
  logic signed [rpc_pkg::ACC_W-1:0]              base;

  assign prod = a * b;
  assign ext  = rpc_pkg::ACC_W'(prod);
  assign base = ctl.first ? '0 : acc;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= ctl.sub ? base - ext : base + ext;
    end
  end

endmodule

// ===== sv/rpc_norm.sv =====
// Quaternion normalize unit: shift search, sum of squares, serial root, serial divide.
`timescale 1ns / 1ps
module rpc_norm (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rpc_pkg::norm_req_t                    req,
  input  logic [3:0][rpc_pkg::PR_W-1:0]         c,
  output rpc_pkg::norm_rsp_t                    rsp,
  output logic [3:0][rpc_pkg::U_W-1:0]          o
);

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_CHK, N_ROOT, N_DLOAD, N_DRUN
  } nstate_t;

  nstate_t                     state;
  logic [3:0][rpc_pkg::PR_W-1:0] m;
  logic [3:0]                  neg;
  logic                        fine;
  logic [1:0]                  idx;
  logic [rpc_pkg::SQ_W-1:0]    s2;
  logic [rpc_pkg::ROOT_W-1:0]  rn;
  logic [rpc_pkg::ROOT_W-1:0]  res;
  logic [4:0]                  j;
  logic [rpc_pkg::R_W-1:0]     rem;
  logic [rpc_pkg::DQ_W-1:0]    lo;
  logic [rpc_pkg::DQ_W-1:0]    qv;
  logic [4:0]                  cnt;

  logic                        big;
  logic [2*16-1:0]             sq;
  logic [rpc_pkg::ROOT_W-1:0]  bitv;
  logic [rpc_pkg::ROOT_W:0]    trial;
  logic                        rge;
  logic [rpc_pkg::R_W-1:0]     rt;
  logic [rpc_pkg::NUM_W-1:0]   num;
  logic [rpc_pkg::R_W:0]       rem2;
  logic                        dge;
  logic [rpc_pkg::DQ_W-1:0]    qn;

  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 4; i++) begin
      big = big | (|m[i][rpc_pkg::PR_W-1:16]);
    end
  end

  assign sq    = m[idx][15:0] * m[idx][15:0];
  assign bitv  = rpc_pkg::ROOT_W'(1) << {j, 1'b0};
  assign trial = {1'b0, res} + {1'b0, bitv};
  assign rge   = {1'b0, rn} >= trial;
  assign rt    = res[rpc_pkg::R_W-1:0];
  assign num   = fine ? (rpc_pkg::NUM_W'(m[idx][15:0]) << rpc_pkg::SH_FINE)
                          + rpc_pkg::NUM_W'(rt >> 1)
                      : (rpc_pkg::NUM_W'(m[idx][15:0]) << rpc_pkg::SH_COARSE)
                          + rpc_pkg::NUM_W'(rt >> 1);
  assign rem2  = {rem, lo[rpc_pkg::DQ_W-1]};
  assign dge   = rem2 >= {1'b0, rt};
  assign qn    = {qv[rpc_pkg::DQ_W-2:0], dge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= N_IDLE;
      rsp.done    <= 1'b0;
      rsp.nonzero <= 1'b0;
    end else begin
      // pulse done on a zero norm or after the last quotient
      rsp.done <= ((state == N_CHK) && (s2 == '0))
                  || ((state == N_DRUN) && (cnt == 5'd1) && (idx == 2'd3));
      case (state)
        N_IDLE: begin
          if (req.start) begin
            fine <= req.fine;
            for (int i = 0; i < 4; i++) begin
              neg[i] <= c[i][rpc_pkg::PR_W-1];
              m[i]   <= c[i][rpc_pkg::PR_W-1] ? -c[i] : c[i];
            end
            state <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          // drop one bit a cycle until every magnitude fits 16 bits
          if (big) begin
            for (int i = 0; i < 4; i++) begin
              m[i] <= m[i] >> 1;
            end
          end else begin
            idx   <= 2'd0;
            s2    <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          s2  <= s2 + rpc_pkg::SQ_W'(sq);
          idx <= idx + 2'd1;
          if (idx == 2'd3) begin
            state <= N_CHK;
          end
        end
        N_CHK: begin
          if (s2 == '0) begin
            rsp.nonzero <= 1'b0;
            state       <= N_IDLE;
          end else begin
            rn    <= {s2, 28'b0};
            res   <= '0;
            j     <= 5'd30;
            state <= N_ROOT;
          end
        end
        N_ROOT: begin
          if (rge) begin
            rn  <= rn - trial[rpc_pkg::ROOT_W-1:0];
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          j <= j - 5'd1;
          if (j == 5'd0) begin
            idx   <= 2'd0;
            state <= N_DLOAD;
          end
        end
        N_DLOAD: begin
          rem   <= fine ? rpc_pkg::R_W'(num >> rpc_pkg::DQ_FINE)
                        : rpc_pkg::R_W'(num >> rpc_pkg::DQ_COARSE);
          lo    <= fine ? num[rpc_pkg::DQ_W-1:0]
                        : {num[rpc_pkg::DQ_COARSE-1:0],
                           (rpc_pkg::DQ_W - rpc_pkg::DQ_COARSE)'(0)};
          qv    <= '0;
          cnt   <= fine ? 5'(rpc_pkg::DQ_FINE) : 5'(rpc_pkg::DQ_COARSE);
          state <= N_DRUN;
        end
        N_DRUN: begin
          rem <= dge ? rpc_pkg::R_W'(rem2 - {1'b0, rt}) : rem2[rpc_pkg::R_W-1:0];
          qv  <= qn;
          lo  <= lo << 1;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            o[idx] <= neg[idx] ? -rpc_pkg::U_W'(qn) : rpc_pkg::U_W'(qn);
            idx    <= idx + 2'd1;
            if (idx == 2'd3) begin
              rsp.nonzero <= 1'b1;
              state       <= N_IDLE;
            end else begin
              state <= N_DLOAD;
            end
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/rpc_chk.sv =====
// Port-level checker for the rigid pose composer, bound to the top level.
`timescale 1ns / 1ps
module rpc_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [0:0]                  s_tuser,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [rpc_pkg::DATA_W-1:0]  m_tdata,
  input logic [rpc_pkg::UOUT_W-1:0]  m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_compose_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == rpc_pkg::KIND_COMPOSE) |=> !s_tready)
    else $error("ready right after a compose transaction");

  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == rpc_pkg::KIND_LOAD) |=> s_tready)
    else $error("load transaction stalled the input");

  a_identity: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |->
      (m_tdata[159:144] == 16'd16384) && (m_tdata[143:96] == 48'd0))
    else $error("invalid orientation without identity quaternion");

endmodule

bind rigid_pose_compose rpc_chk u_rpc_chk (.*);

// ===== dv/tb_rigid_pose_compose.sv =====
// Testbench for the rigid pose composer: random and directed pose streams, checked by a predictor.
`timescale 1ns / 1ps
module tb_rigid_pose_compose;

  // One composed pose as it leaves the block, fields split out for checking.
  typedef struct packed {
    logic [3:0][rpc_pkg::QW-1:0] quat;   // x, y, z, w
    logic [2:0][rpc_pkg::PW-1:0] pos;    // x, y, z
    logic                        pos_ok;
    logic                        ori_ok;
  } pose_out_t;

  // Predicts composed poses and holds them until the block delivers them.
  class compose_predictor;
    longint    parent_pos[3];
    longint    parent_quat[4];   // x, y, z, w, stored raw
    pose_out_t expected_poses[$];
    int        errors, loads, composes, zero_parent, zero_product, saturated;

    function new();
      parent_pos = '{0, 0, 0};
      parent_quat = '{0, 0, 0, 64'd1 << (rpc_pkg::QW - 2)};
    endfunction

    static function longint unsigned magn(longint x);
      return (x < 0) ? longint'(-x) : x;
    endfunction

    static function longint round_shift(longint x, int s);
      longint unsigned m;
      m = (magn(x) + (64'd1 << (s - 1))) >> s;
      return (x < 0) ? -longint'(m) : longint'(m);
    endfunction

    static function longint clamp(longint x, int w);
      longint hi, lo;
      hi = (64'sd1 <<< (w - 1)) - 1;
      lo = -hi - 1;
      return (x > hi) ? hi : (x < lo) ? lo : x;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // Scale a 4-vector to unit length with f fraction bits; 0 when it is all zero.
    static function bit unit_scale(input longint c[4], input int f, output longint o[4]);
      longint unsigned m[4], mx, s2, r, v;
      int s;
      mx = 0;
      s2 = 0;
      s = 0;
      for (int i = 0; i < 4; i++) begin
        m[i] = magn(c[i]);
        if (m[i] > mx) mx = m[i];
      end
      while ((mx >> s) >= 65536) s++;
      for (int i = 0; i < 4; i++) begin
        m[i] >>= s;
        s2 += m[i] * m[i];
      end
      if (s2 == 0) return 0;
      r = int_sqrt(s2 << 28);
      for (int i = 0; i < 4; i++) begin
        v = ((m[i] << (f + 14)) + (r >> 1)) / r;
        o[i] = (c[i] < 0) ? -longint'(v) : longint'(v);
      end
      return 1;
    endfunction

    function void note_input(logic kind, logic [rpc_pkg::DATA_W-1:0] d);
      longint b[4], v[3], pr[4], u[4], oq[4], t[3], r[3], a[4], op[3];
      pose_out_t e;
      bit pv, ov;
      for (int i = 0; i < 4; i++)
        b[i] = longint'($signed(d[i*rpc_pkg::QW +: rpc_pkg::QW]));
      for (int i = 0; i < 3; i++)
        v[i] = longint'($signed(d[4*rpc_pkg::QW + i*rpc_pkg::PW +: rpc_pkg::PW]));
      if (kind == rpc_pkg::KIND_LOAD) begin
        loads++;
        parent_quat = b;
        parent_pos = v;
        return;
      end
      composes++;
      a = parent_quat;
      op = '{0, 0, 0};
      // Hamilton product, parent on the left.
      pr[0] = a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1];
      pr[1] = a[3]*b[1] - a[0]*b[2] + a[1]*b[3] + a[2]*b[0];
      pr[2] = a[3]*b[2] + a[0]*b[1] - a[1]*b[0] + a[2]*b[3];
      pr[3] = a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2];
      pv = unit_scale(a, 24, u);
      if (pv) begin
        t[0] = round_shift(u[1]*v[2] - u[2]*v[1], 23);
        t[1] = round_shift(u[2]*v[0] - u[0]*v[2], 23);
        t[2] = round_shift(u[0]*v[1] - u[1]*v[0], 23);
        r[0] = v[0] + round_shift(u[3]*t[0] + u[1]*t[2] - u[2]*t[1], 24);
        r[1] = v[1] + round_shift(u[3]*t[1] + u[2]*t[0] - u[0]*t[2], 24);
        r[2] = v[2] + round_shift(u[3]*t[2] + u[0]*t[1] - u[1]*t[0], 24);
        for (int i = 0; i < 3; i++) begin
          op[i] = clamp(parent_pos[i] + r[i], rpc_pkg::PW);
          if (op[i] != parent_pos[i] + r[i]) saturated++;
        end
      end else begin
        zero_parent++;
      end
      ov = unit_scale(pr, rpc_pkg::QW - 2, oq);
      if (ov) begin
        for (int i = 0; i < 4; i++) oq[i] = clamp(oq[i], rpc_pkg::QW);
      end else begin
        zero_product++;
        oq = '{0, 0, 0, 64'd1 << (rpc_pkg::QW - 2)};
      end
      for (int i = 0; i < 3; i++) e.pos[i] = op[i][rpc_pkg::PW-1:0];
      for (int i = 0; i < 4; i++) e.quat[i] = oq[i][rpc_pkg::QW-1:0];
      e.pos_ok = pv;
      e.ori_ok = ov;
      expected_poses.push_back(e);
    endfunction

    function void check_result(logic [rpc_pkg::DATA_W-1:0] d, logic [rpc_pkg::UOUT_W-1:0] flags);
      pose_out_t e, got;
      string pos_names[3], quat_names[4];
      pos_names = '{"out_pos_x", "out_pos_y", "out_pos_z"};
      quat_names = '{"out_quat_x", "out_quat_y", "out_quat_z", "out_quat_w"};
      if (expected_poses.size() == 0) begin
        $error("result arrived with no compose outstanding");
        errors++;
        return;
      end
      e = expected_poses.pop_front();
      got = {d, flags[0], flags[1]};
      for (int i = 0; i < 3; i++)
        if (got.pos[i] !== e.pos[i]) begin
          $error("%s expected %0d got %0d", pos_names[i], $signed(e.pos[i]),
                 $signed(got.pos[i]));
          errors++;
        end
      for (int i = 0; i < 4; i++)
        if (got.quat[i] !== e.quat[i]) begin
          $error("%s expected %0d got %0d", quat_names[i], $signed(e.quat[i]),
                 $signed(got.quat[i]));
          errors++;
        end
      if (got.pos_ok !== e.pos_ok) begin
        $error("position_valid expected %0b got %0b", e.pos_ok, got.pos_ok);
        errors++;
      end
      if (got.ori_ok !== e.ori_ok) begin
        $error("orientation_valid expected %0b got %0b", e.ori_ok, got.ori_ok);
        errors++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [rpc_pkg::DATA_W-1:0]   s_tdata = '0;
  logic [0:0]                   s_tuser = rpc_pkg::KIND_LOAD;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [rpc_pkg::DATA_W-1:0]   m_tdata;
  logic [rpc_pkg::UOUT_W-1:0]   m_tuser;

  compose_predictor pred = new();
  bit calm = 0;        // when set, neither side idles
  int stall_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rigid_pose_compose dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Hold off the result side at random: mostly short stalls, now and then a long one.
  always @(posedge clk) begin
    if (rst || calm) begin
      m_tready <= !rst;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(99) < 4)
        stall_left <= ($urandom_range(9) == 0) ? $urandom_range(400, 80) : $urandom_range(6, 1);
    end
  end

  // Check every result transaction against the oldest prediction.
  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) pred.check_result(m_tdata, m_tuser);

  function automatic int pick_gap();
    int p;
    if (calm) return 0;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(80, 20);
  endfunction

  function automatic logic [rpc_pkg::DATA_W-1:0] pack_pose(logic [3:0][rpc_pkg::QW-1:0] q,
                                                           logic [2:0][rpc_pkg::PW-1:0] p);
    return {p[2], p[1], p[0], q[3], q[2], q[1], q[0]};
  endfunction

  // Offer one pose and hold it until the block takes the transaction.
  task automatic send_pose(input logic kind, input logic [rpc_pkg::DATA_W-1:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tuser <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred.note_input(kind, d);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pred.expected_poses.size() != 0) @(posedge clk);
  endtask

  function automatic logic [3:0][rpc_pkg::QW-1:0] rand_quat();
    logic [3:0][rpc_pkg::QW-1:0] q;
    int p;
    p = $urandom_range(99);
    for (int i = 0; i < 4; i++) begin
      if (p < 40) q[i] = rpc_pkg::QW'($urandom());                    // anything
      else if (p < 85)                                                 // near unit
        q[i] = rpc_pkg::QW'($signed($urandom_range(32768)) - 16384);
      else if (p < 92)                                                 // one axis
        q[i] = ($urandom_range(3) == i) ? rpc_pkg::QW'($urandom()) : '0;
      else if (p < 96) q[i] = $urandom_range(1) ? 16'h8000 : 16'h7fff; // extremes
      else q[i] = '0;                                                  // zero norm
    end
    return q;
  endfunction

  function automatic logic [2:0][rpc_pkg::PW-1:0] rand_pos();
    logic [2:0][rpc_pkg::PW-1:0] p;
    int s;
    s = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      if (s < 40) p[i] = $urandom();
      else if (s < 80) p[i] = rpc_pkg::PW'($signed($urandom_range(1 << 22)) - (1 << 21));
      else p[i] = $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                      : 32'h8000_0000 + $urandom_range(3);
    end
    return p;
  endfunction

  localparam logic [rpc_pkg::QW-1:0] QMAX = 16'h7fff, QMIN = 16'h8000;
  localparam logic [rpc_pkg::PW-1:0] PMAX = 32'h7fff_ffff, PMIN = 32'h8000_0000;

  initial begin
    int sent;
    int run;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset parent (identity), extremes, zero quaternions, saturation.
    calm = 1;
    send_pose(rpc_pkg::KIND_COMPOSE,
              pack_pose({rpc_pkg::QUAT_ONE, 48'd0}, {32'd0, 32'd65536, 32'd0}));
    send_pose(rpc_pkg::KIND_COMPOSE, pack_pose({QMIN, QMIN, QMIN, QMIN}, {PMIN, PMIN, PMIN}));
    send_pose(rpc_pkg::KIND_COMPOSE, pack_pose({QMAX, QMAX, QMAX, QMAX}, {PMAX, PMAX, PMAX}));
    send_pose(rpc_pkg::KIND_COMPOSE, pack_pose('0, {PMAX, PMIN, 32'd0}));   // zero product
    send_pose(rpc_pkg::KIND_LOAD, pack_pose({QMAX, QMAX, QMAX, QMAX}, {PMAX, PMAX, PMAX}));
    send_pose(rpc_pkg::KIND_COMPOSE,                                         // saturate high
              pack_pose({rpc_pkg::QUAT_ONE, 48'd0}, {PMAX, PMAX, PMAX}));
    send_pose(rpc_pkg::KIND_COMPOSE, pack_pose({QMIN, QMIN, QMIN, QMIN}, {PMIN, PMIN, PMIN}));
    send_pose(rpc_pkg::KIND_LOAD, pack_pose({QMIN, QMIN, QMIN, QMIN}, {PMIN, PMIN, PMIN}));
    send_pose(rpc_pkg::KIND_COMPOSE, pack_pose({QMAX, 16'd0, QMIN, 16'd1}, {PMIN, PMIN, PMIN}));
    send_pose(rpc_pkg::KIND_COMPOSE,
              pack_pose({16'd0, 16'd0, 16'd0, 16'd1}, {PMAX, 32'd1, PMIN}));
    send_pose(rpc_pkg::KIND_LOAD, pack_pose('0, {32'd100, 32'd200, 32'd300})); // zero parent
    send_pose(rpc_pkg::KIND_COMPOSE,
              pack_pose({rpc_pkg::QUAT_ONE, 48'd0}, {PMAX, PMIN, 32'd7}));
    send_pose(rpc_pkg::KIND_COMPOSE, pack_pose('0, {32'd1, 32'd2, 32'd3}));    // both zero
    send_pose(rpc_pkg::KIND_LOAD,
              pack_pose({16'd0, 16'd0, 16'd1, 16'd0}, {PMIN, PMAX, 32'd0}));
    send_pose(rpc_pkg::KIND_COMPOSE,
              pack_pose({16'd1, 16'd0, 16'd0, 16'd0}, {32'd65536, 32'd0, PMAX}));
    send_pose(rpc_pkg::KIND_LOAD,
              pack_pose({16'd1, 16'd1, 16'd1, 16'd1}, {32'd0, 32'd0, 32'd0}));
    send_pose(rpc_pkg::KIND_COMPOSE, pack_pose({QMIN, QMAX, QMIN, QMAX}, {PMAX, PMIN, PMAX}));
    calm = 0;
    // Let the block empty before going random.
    drain();

    // Random: mostly a load followed by a few composes against it.
    sent = 0;
    while (sent < 1800) begin
      calm = (sent / 300) % 3 == 2;
      if ($urandom_range(19) != 0) begin
        send_pose(rpc_pkg::KIND_LOAD, pack_pose(rand_quat(), rand_pos()));
        sent++;
      end
      run = $urandom_range(6, 1);
      repeat (run) begin
        send_pose(rpc_pkg::KIND_COMPOSE, pack_pose(rand_quat(), rand_pos()));
        sent++;
      end
      if (sent >= 900 && sent < 907) drain();
    end
    calm = 0;

    drain();
    repeat (400) @(posedge clk);
    $display("covered %0d loads and %0d composes: %0d with zero parent, %0d with zero product",
             pred.loads, pred.composes, pred.zero_parent, pred.zero_product);
    $display("%0d position components clamped at the range limit", pred.saturated);
    if (pred.errors == 0 && pred.expected_poses.size() == 0)
      $display("rigid_pose_compose: match");
    else
      $display("rigid_pose_compose: mismatch");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout waiting for results");
    $display("rigid_pose_compose: mismatch");
    $finish;
  end

endmodule
